>>> hw/rtl/dshb_pkg.sv
// Package with the payload types, register indexes and zone codes of the dashboard monitor.
`default_nettype none

package dshb_pkg;

    localparam int unsigned NODE_COUNT = 3;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_YELLOW  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_ORANGE  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_RED     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BATT_RED     = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BATT_YELLOW  = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HB_TIMEOUT   = 8'd5;

    // Register reset values.
    localparam logic [15:0] TEMP_YELLOW_RST = 16'd60;
    localparam logic [15:0] TEMP_ORANGE_RST = 16'd80;
    localparam logic [15:0] TEMP_RED_RST    = 16'd100;
    localparam logic [15:0] BATT_RED_RST    = 16'd10500;
    localparam logic [15:0] BATT_YELLOW_RST = 16'd11500;
    localparam logic [7:0]  HB_TIMEOUT_RST  = 8'd5;

    // rpm * 60 / 1000 = rpm * 3 / 50, taken as rpm * ceil(3 * 2^24 / 50) >> 24.
    // The rounding error stays below 1/50 over the whole 16-bit range, so the
    // floor is exact.
    localparam int unsigned  SPEED_SHIFT = 24;
    localparam logic [19:0]  SPEED_MULT  = 20'd1006633;

    localparam logic [7:0] TORQUE_MAX = 8'd100;
    localparam logic [7:0] STALE_MAX  = 8'd255;

    localparam logic [1:0] TZ_GREEN  = 2'd0;
    localparam logic [1:0] TZ_YELLOW = 2'd1;
    localparam logic [1:0] TZ_ORANGE = 2'd2;
    localparam logic [1:0] TZ_RED    = 2'd3;

    localparam logic [1:0] BZ_GREEN  = 2'd0;
    localparam logic [1:0] BZ_YELLOW = 2'd1;
    localparam logic [1:0] BZ_RED    = 2'd2;

    localparam int unsigned WARN_FAULT = 0;
    localparam int unsigned WARN_TEMP  = 1;
    localparam int unsigned WARN_BATT  = 2;
    localparam int unsigned WARN_ESTOP = 3;
    localparam int unsigned WARN_OVC   = 4;

    typedef struct packed {
        logic [15:0] motor_rpm;
        logic [7:0]  torque_request;
        logic [15:0] motor_temp;
        logic [15:0] battery_mv;
        logic [15:0] fault_code;
        logic        estop_flag;
        logic        overcurrent_flag;
        logic [7:0]  node0_alive;
        logic [7:0]  node1_alive;
        logic [7:0]  node2_alive;
    } in_item_t;

    typedef struct packed {
        logic [11:0] display_speed;
        logic [6:0]  torque_shown;
        logic [1:0]  temp_zone;
        logic [1:0]  battery_zone;
        logic [4:0]  warning_bits;
        logic        node0_ok;
        logic        node1_ok;
        logic        node2_ok;
    } out_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/dshb_hb_watch.sv
// Heartbeat tracker for one remote node: last alive value, stale count and health flag.
`default_nettype none

module dshb_hb_watch
    import dshb_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       update,
    input  wire logic [7:0] alive,
    input  wire logic [7:0] timeout,
    output logic            ok_next
);

    logic [7:0] last_alive_reg;
    logic [7:0] stale_count_reg;
    logic       healthy_reg;
    logic [7:0] last_alive_next;
    logic [7:0] stale_count_next;
    logic       changed;

    assign changed = (alive != last_alive_reg);

    always_comb begin
        if (changed) begin
            last_alive_next  = alive;
            stale_count_next = '0;
            ok_next          = 1'b1;
        end else begin
            last_alive_next  = last_alive_reg;
            stale_count_next = (stale_count_reg == STALE_MAX) ? stale_count_reg
                                                              : stale_count_reg + 8'd1;
            // Once unhealthy, the node stays so until its counter moves.
            ok_next          = healthy_reg && (stale_count_next <= timeout);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_alive_reg  <= '0;
            stale_count_reg <= '0;
            healthy_reg     <= 1'b1;
        end else if (update) begin
            last_alive_reg  <= last_alive_next;
            stale_count_reg <= stale_count_next;
            healthy_reg     <= ok_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/dashboard_status_and_heartbeat_monitor.sv
// Top level of the dashboard status and heartbeat monitor.
// Each transfer on the s_ channel is one snapshot of vehicle signals and gives exactly one
// result transfer on the m_ channel, in order. A snapshot is captured into an input register,
// evaluated combinationally (speed scaling by a constant multiply, torque clamp, threshold
// zones, warning word, heartbeat update) and written to a result register. One snapshot is
// taken every cycle while m_ready is high; the result register and the input register stall
// together only when a finished result is not taken. Heartbeat state advances once per
// snapshot, as it moves into the result register. Thresholds are written on the cfg_ port,
// which is always ready; indexes above five are ignored, and writes should only happen
// while no snapshot is in flight.
`default_nettype none

module dashboard_status_and_heartbeat_monitor
    import dshb_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [15:0] temp_yellow_reg;
    logic [15:0] temp_orange_reg;
    logic [15:0] temp_red_reg;
    logic [15:0] batt_red_reg;
    logic [15:0] batt_yellow_reg;
    logic [7:0]  hb_timeout_reg;

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t out_item_next;

    logic        advance;
    logic        hb_update;
    logic [35:0] speed_prod;
    logic [1:0]  temp_zone;
    logic [1:0]  batt_zone;
    logic [NODE_COUNT-1:0] node_ok;
    logic [7:0]  node_alive [NODE_COUNT];

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || advance;
    assign hb_update = advance && in_valid_reg;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_yellow_reg <= TEMP_YELLOW_RST;
            temp_orange_reg <= TEMP_ORANGE_RST;
            temp_red_reg    <= TEMP_RED_RST;
            batt_red_reg    <= BATT_RED_RST;
            batt_yellow_reg <= BATT_YELLOW_RST;
            hb_timeout_reg  <= HB_TIMEOUT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_TEMP_YELLOW: temp_yellow_reg <= cfg_data;
                REG_TEMP_ORANGE: temp_orange_reg <= cfg_data;
                REG_TEMP_RED:    temp_red_reg    <= cfg_data;
                REG_BATT_RED:    batt_red_reg    <= cfg_data;
                REG_BATT_YELLOW: batt_yellow_reg <= cfg_data;
                REG_HB_TIMEOUT:  hb_timeout_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
        if (hb_update) begin
            out_item_reg <= out_item_next;
        end
    end

    assign speed_prod = 36'(in_item_reg.motor_rpm) * 36'(SPEED_MULT);

    always_comb begin
        priority if (in_item_reg.motor_temp >= temp_red_reg) begin
            temp_zone = TZ_RED;
        end else if (in_item_reg.motor_temp >= temp_orange_reg) begin
            temp_zone = TZ_ORANGE;
        end else if (in_item_reg.motor_temp >= temp_yellow_reg) begin
            temp_zone = TZ_YELLOW;
        end else begin
            temp_zone = TZ_GREEN;
        end
    end

    always_comb begin
        priority if (in_item_reg.battery_mv < batt_red_reg) begin
            batt_zone = BZ_RED;
        end else if (in_item_reg.battery_mv <= batt_yellow_reg) begin
            batt_zone = BZ_YELLOW;
        end else begin
            batt_zone = BZ_GREEN;
        end
    end

    assign node_alive[0] = in_item_reg.node0_alive;
    assign node_alive[1] = in_item_reg.node1_alive;
    assign node_alive[2] = in_item_reg.node2_alive;

    for (genvar n = 0; n < NODE_COUNT; n++) begin : g_node
        dshb_hb_watch u_watch (
            .aclk    (aclk),
            .aresetn (aresetn),
            .update  (hb_update),
            .alive   (node_alive[n]),
            .timeout (hb_timeout_reg),
            .ok_next (node_ok[n])
        );
    end

    always_comb begin
        out_item_next.display_speed = speed_prod[SPEED_SHIFT +: 12];
        out_item_next.torque_shown  = (in_item_reg.torque_request > TORQUE_MAX)
                                      ? TORQUE_MAX[6:0] : in_item_reg.torque_request[6:0];
        out_item_next.temp_zone     = temp_zone;
        out_item_next.battery_zone  = batt_zone;
        out_item_next.warning_bits             = '0;
        out_item_next.warning_bits[WARN_FAULT] = (in_item_reg.fault_code != '0);
        out_item_next.warning_bits[WARN_TEMP]  = (temp_zone == TZ_ORANGE) || (temp_zone == TZ_RED);
        out_item_next.warning_bits[WARN_BATT]  = (batt_zone == BZ_RED);
        out_item_next.warning_bits[WARN_ESTOP] = in_item_reg.estop_flag;
        out_item_next.warning_bits[WARN_OVC]   = in_item_reg.overcurrent_flag;
        out_item_next.node0_ok      = node_ok[0];
        out_item_next.node1_ok      = node_ok[1];
        out_item_next.node2_ok      = node_ok[2];
    end

    // The clamp and the speed scaling must never leave their ranges.
    a_torque_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.torque_shown <= 7'd100))
        else $error("torque_shown above 100");

    a_speed_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.display_speed <= 12'd3932))
        else $error("display_speed out of range");

    // The warning word must agree with the zones delivered alongside it.
    a_warn_zones: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.warning_bits[WARN_TEMP] == m_data.temp_zone[1]) &&
                     (m_data.warning_bits[WARN_BATT] == (m_data.battery_zone == BZ_RED))))
        else $error("warning bits disagree with zones");

    // A waiting result may not be overwritten by the next snapshot.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> (out_valid_reg && $stable(out_item_reg)))
        else $error("pending result overwritten");

endmodule

`default_nettype wire
